// ===== rtl/keyed_record_table_core_macros.svh =====
// Assertion macros for the keyed record table core.
// Used by the top level; no other dependencies.
`ifndef KEYED_RECORD_TABLE_CORE_MACROS_SVH
`define KEYED_RECORD_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define KRT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define KRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/krt_pkg.sv =====
// Shared types and constants for the keyed record table core.
// No dependencies; imported by krt_seq and the top level.
`timescale 1ns / 1ps
`default_nettype none

package krt_pkg;

   localparam int TABLE_DEPTH_DEF = 128;
   localparam int FIELD_W         = 32;
   localparam int COUNT_OUT_W     = 8;

   typedef enum logic [1:0] {
      FUNC_INSERT       = 2'd0,
      FUNC_SET_QUANTITY = 2'd1,
      FUNC_SET_PRICE    = 2'd2,
      FUNC_REMOVE       = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INSERT,
      ST_SEARCH,
      ST_SHIFT,
      ST_RESP
   } state_type;

   // One table entry as stored in the record memory.
   typedef struct packed {
      logic signed [FIELD_W-1:0] code;
      logic signed [FIELD_W-1:0] quantity;
      logic signed [FIELD_W-1:0] price;
   } rec_type;

   // Result handed from the sequencer to the output register.
   typedef struct packed {
      logic                   push;
      logic                   ok;
      logic [COUNT_OUT_W-1:0] entry_count;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/krt_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module krt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/krt_seq.sv =====
// Operation sequencer: linear search, field update, append and compaction shift
// over the record memory. Depends on krt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module krt_seq import krt_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
   localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [1:0]                req_func,
   input  wire logic signed [FIELD_W-1:0] req_item_code,
   input  wire logic signed [FIELD_W-1:0] req_item_quantity,
   input  wire logic signed [FIELD_W-1:0] req_item_price,
   input  wire logic                      rsp_free,
   output rsp_type                        rsp_out,
   output logic                           ram_wr_en,
   output logic [AW-1:0]                  ram_wr_addr,
   output rec_type                        ram_wr_data,
   output logic                           ram_rd_en,
   output logic [AW-1:0]                  ram_rd_addr,
   input  rec_type                        ram_rd_data
);

   state_type         state_ff, state_in;
   func_type          func_ff, func_in;
   rec_type           req_ff, req_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     idx_ff, idx_in;        // next entry to read
   logic              pend_ff, pend_in;      // read data due this cycle
   logic [CW-1:0]     pend_idx_ff, pend_idx_in;
   logic              ok_ff, ok_in;
   logic              hit;
   logic              more;
   logic [CW-1:0]     wr_idx;
   logic [CW+COUNT_OUT_W-1:0] count_ext;

   assign hit       = pend_ff && (ram_rd_data.code == req_ff.code);
   assign more      = idx_ff < count_ff;
   assign count_ext = {{COUNT_OUT_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      func_ff     <= func_in;
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      pend_idx_ff <= pend_idx_in;
      ok_ff       <= ok_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (func_type'(req_func) == FUNC_INSERT) ? ST_INSERT : ST_SEARCH;
            end
         end
         ST_INSERT: state_in = ST_RESP;
         ST_SEARCH: begin
            if (hit) begin
               state_in = (func_ff == FUNC_REMOVE) ? ST_SHIFT : ST_RESP;
            end else if (!pend_ff && !more) begin
               state_in = ST_RESP;
            end
         end
         ST_SHIFT: begin
            if (!pend_ff && !more) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      func_in     = func_ff;
      req_in      = req_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      ok_in       = ok_ff;
      req_ready   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_data = req_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff[AW-1:0];
      wr_idx      = count_ff;
      rsp_out.push        = 1'b0;
      rsp_out.ok          = ok_ff;
      rsp_out.entry_count = count_ext[COUNT_OUT_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               func_in         = func_type'(req_func);
               req_in.code     = req_item_code;
               req_in.quantity = req_item_quantity;
               req_in.price    = req_item_price;
               idx_in          = '0;
            end
         end
         ST_INSERT: begin
            if (count_ff < CW'(TABLE_DEPTH)) begin
               ram_wr_en = 1'b1;
               count_in  = count_ff + 1'b1;
               ok_in     = 1'b1;
            end else begin
               ok_in = 1'b0;
            end
         end
         ST_SEARCH: begin
            ok_in = 1'b0;
            if (hit) begin
               ok_in  = 1'b1;
               wr_idx = pend_idx_ff;
               ram_wr_data = ram_rd_data;
               if (func_ff == FUNC_SET_QUANTITY) begin
                  ram_wr_en = 1'b1;
                  ram_wr_data.quantity = req_ff.quantity;
               end else if (func_ff == FUNC_SET_PRICE) begin
                  ram_wr_en = 1'b1;
                  ram_wr_data.price = req_ff.price;
               end else begin
                  // remove: compaction starts with the entry above the match
                  idx_in = pend_idx_ff + 1'b1;
               end
            end else if (more) begin
               ram_rd_en   = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = idx_ff;
               idx_in      = idx_ff + 1'b1;
            end
         end
         ST_SHIFT: begin
            // entry k read last cycle is written to k-1 while k+1 is read
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               wr_idx      = pend_idx_ff - 1'b1;
               ram_wr_data = ram_rd_data;
            end
            if (more) begin
               ram_rd_en   = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = idx_ff;
               idx_in      = idx_ff + 1'b1;
            end else if (!pend_ff) begin
               count_in = count_ff - 1'b1;
            end
         end
         ST_RESP: begin
            rsp_out.push = rsp_free;
         end
         default: begin
         end
      endcase
      ram_wr_addr = wr_idx[AW-1:0];
   end

endmodule

`default_nettype wire

// ===== rtl/keyed_record_table_core.sv =====
// Top level of the keyed record table: record memory, sequencer, output register.
// Depends on krt_pkg, krt_ram, krt_seq and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

// Unsorted, compacted table of up to TABLE_DEPTH records (code, quantity,
// price in hundredths), kept in one record memory with a single read port.
// One item is handled at a time; the next is taken once the result has gone
// to the output register, which may still be waiting on rsp_ready. An insert
// appends after the valid entries; an update walks the entries up to the match,
// and a remove walks up to the match and then shifts each entry above it down
// by one. While the result waits for a full output register, no new item is
// taken. The memory read port walks the entries one per cycle.
// No clearing pass is needed after reset: only entries below the count are
// ever read.

`include "keyed_record_table_core_macros.svh"

module keyed_record_table_core import krt_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [1:0]                req_func,
   input  wire logic signed [FIELD_W-1:0] req_item_code,
   input  wire logic signed [FIELD_W-1:0] req_item_quantity,
   input  wire logic signed [FIELD_W-1:0] req_item_price,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           rsp_ok,
   output logic [COUNT_OUT_W-1:0]         rsp_entry_count
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic                   ram_wr_en;
   logic [AW-1:0]          ram_wr_addr;
   rec_type                ram_wr_data;
   logic                   ram_rd_en;
   logic [AW-1:0]          ram_rd_addr;
   rec_type                ram_rd_data;
   rsp_type                seq_rsp;
   logic                   rsp_free;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_ok_ff, rsp_ok_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   krt_ram #(
      .WIDTH ($bits(rec_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   krt_seq #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_item_code     (req_item_code),
      .req_item_quantity (req_item_quantity),
      .req_item_price    (req_item_price),
      .rsp_free          (rsp_free),
      .rsp_out           (seq_rsp),
      .ram_wr_en         (ram_wr_en),
      .ram_wr_addr       (ram_wr_addr),
      .ram_wr_data       (ram_wr_data),
      .ram_rd_en         (ram_rd_en),
      .ram_rd_addr       (ram_rd_addr),
      .ram_rd_data       (ram_rd_data)
   );

   // output register: free when empty or being drained this cycle
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_count_in = rsp_count_ff;
      if (seq_rsp.push) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = seq_rsp.ok;
         rsp_count_in = seq_rsp.entry_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ok_ff    <= rsp_ok_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_entry_count = rsp_count_ff;

   `KRT_ASSERT_NOW(a_push_into_free, clock, reset, seq_rsp.push, rsp_free, "result pushed into a full output register")
   `KRT_ASSERT_NEXT(a_push_shows, clock, reset, seq_rsp.push, rsp_valid, "pushed result not shown on the output")
   `KRT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "new item taken while one is in work")

endmodule

`default_nettype wire
